### rtl/lsps_pkg.sv
package lsps_pkg;

  localparam int NumSens   = 6;
  localparam int AdcW      = 10;
  localparam int FuncW     = 2;
  localparam int PwmW      = 8;
  localparam int PosW      = 13;
  localparam int StrW      = 13;
  localparam int ThrW      = 13;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;
  localparam int IdxW      = 3;
  localparam int DvdW      = 23;
  localparam int DvsW      = 13;
  localparam int WsumW     = 24;
  localparam int NormW     = 11;

  localparam int ScaleMax  = 1000;
  localparam int AdcTop    = 1023;
  localparam int PwmTop    = 255;

  localparam logic [FuncW-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CAL   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RUN   = 2'd2;
  localparam logic [FuncW-1:0] FUNC_RSVD  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_BASE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THR   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MINR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BLACK = 3'd4;

  localparam logic [PwmW-1:0] BaseReset  = 8'd100;
  localparam logic [PwmW-1:0] GainReset  = 8'd20;
  localparam logic [ThrW-1:0] ThrReset   = 13'd300;
  localparam logic [AdcW-1:0] MinrReset  = 10'd30;

  localparam logic [1:0] DIV_SCALE = 2'd0;
  localparam logic [1:0] DIV_CENT  = 2'd1;
  localparam logic [1:0] DIV_GAIN  = 2'd2;

  typedef struct packed {
    logic            load;
    logic            cal_clr;
    logic            cal_fold;
    logic            div_start;
    logic            acc;
    logic [1:0]      div_sel;
    logic [IdxW-1:0] idx;
    logic            out_load;
    logic            out_zero;
  } lsps_cmd_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             div_done;
  } lsps_stat_t;

  function automatic logic signed [PosW-1:0] pos_weight(input logic [IdxW-1:0] k);
    logic signed [PosW-1:0] w;
    case (k)
      3'd0:    w = -13'sd2500;
      3'd1:    w = -13'sd1500;
      3'd2:    w = -13'sd500;
      3'd3:    w = 13'sd500;
      3'd4:    w = 13'sd1500;
      default: w = 13'sd2500;
    endcase
    return w;
  endfunction

endpackage

### rtl/lsps_div.sv
module lsps_div import lsps_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DvsW-1:0] divisor,
  output logic            done,
  output logic [DvdW-1:0] quotient
);

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_r;
  logic [DvsW-1:0] dvs_r;
  logic [DvsW-1:0] rem_r;
  logic [CntW-1:0] cnt_r;
  logic            done_r;
  logic [DvsW:0]   shifted;
  logic            fits;

  assign shifted = {rem_r, dvd_r[DvdW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CntW'(DvdW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      // restoring step, quotient bits shift in behind the dividend
      rem_r <= fits ? DvsW'(shifted - {1'b0, dvs_r}) : shifted[DvsW-1:0];
      dvd_r <= {dvd_r[DvdW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### rtl/lsps_ctrl.sv
module lsps_ctrl import lsps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  lsps_stat_t stat,
  output lsps_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [IdxW-1:0] k_r, k_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic            zero_r, zero_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    cmd.idx       = k_r;
    cmd.out_zero  = zero_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        zero_nxt  = 1'b1;
        state_nxt = S_FIN;
        case (stat.func)
          FUNC_CLEAR: cmd.cal_clr  = 1'b1;
          FUNC_CAL:   cmd.cal_fold = 1'b1;
          FUNC_RUN: begin
            zero_nxt  = 1'b0;
            k_nxt     = '0;
            sel_nxt   = DIV_SCALE;
            state_nxt = S_DSTART;
          end
          default: ;
        endcase
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.acc   = 1'b1;
          state_nxt = S_DSTART;
          case (sel_r)
            DIV_SCALE: begin
              if (k_r == IdxW'(NumSens - 1)) sel_nxt = DIV_CENT;
              else k_nxt = k_r + 1'b1;
            end
            DIV_CENT: sel_nxt = DIV_GAIN;
            default:  state_nxt = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      sel_r       <= DIV_SCALE;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      sel_r       <= sel_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

### rtl/lsps_dp.sv
module lsps_dp import lsps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsps_cmd_t            cmd,
  output lsps_stat_t           stat,
  input  logic [FuncW-1:0]     in_func,
  input  logic [AdcW-1:0]      in_adc [NumSens],
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output logic [PwmW-1:0]      left_pwm,
  output logic [PwmW-1:0]      right_pwm,
  output logic signed [PosW-1:0] centroid,
  output logic [StrW-1:0]      strength_sum,
  output logic                 line_found
);

  logic [PwmW-1:0]  base_r, gain_r;
  logic [ThrW-1:0]  thr_r;
  logic [AdcW-1:0]  minr_r;
  logic             black_r;

  logic [FuncW-1:0] func_r;
  logic [AdcW-1:0]  smp_r  [NumSens];
  logic [AdcW-1:0]  lo_r   [NumSens];
  logic [AdcW-1:0]  hi_r   [NumSens];

  logic                   uncal_r, narrow_r;
  logic signed [WsumW-1:0] wsum_r;
  logic [StrW-1:0]        total_r;
  logic signed [PosW-1:0] pos_r, corr_r;

  logic [PwmW-1:0]        left_r, right_r;
  logic signed [PosW-1:0] opos_r;
  logic [StrW-1:0]        ostr_r;
  logic                   found_r;

  // per-sensor front end
  logic [AdcW-1:0]  s, lo, hi, v, span, off;
  logic             uncal, narrow;
  logic [19:0]      prod;

  always_comb begin
    s      = smp_r[cmd.idx];
    lo     = lo_r[cmd.idx];
    hi     = hi_r[cmd.idx];
    uncal  = lo > hi;
    span   = hi - lo;
    v      = (s < lo) ? lo : ((s > hi) ? hi : s);
    off    = v - lo;
    narrow = (span == '0) || (span < minr_r);
    prod   = off * 10'(ScaleMax);
  end

  // divider operand selection
  logic [DvdW-1:0]  div_dvd;
  logic [DvsW-1:0]  div_dvs;
  logic [DvdW-1:0]  quot;
  logic             div_done;
  logic [WsumW-1:0] wsum_mag;
  logic [PosW-1:0]  pos_mag;

  assign wsum_mag = wsum_r[WsumW-1] ? WsumW'(-wsum_r) : WsumW'(wsum_r);
  assign pos_mag  = pos_r[PosW-1] ? PosW'(-pos_r) : PosW'(pos_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_SCALE: begin
        div_dvd = DvdW'(prod);
        div_dvs = DvsW'(span);
      end
      DIV_CENT: begin
        div_dvd = wsum_mag[DvdW-1:0];
        div_dvs = total_r;
      end
      default: begin
        div_dvd = DvdW'(pos_mag);
        div_dvs = (gain_r == '0) ? DvsW'(1) : DvsW'(gain_r);
      end
    endcase
  end

  lsps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quot)
  );

  // normalized sample
  logic [NormW-1:0]        q, nrm;
  logic signed [WsumW-1:0] wprod;
  logic signed [PosW-1:0]  qsig;

  always_comb begin
    q = uncal_r ? NormW'(ScaleMax) : quot[NormW-1:0];
    if (narrow_r && !uncal_r) nrm = '0;
    else if (black_r)         nrm = NormW'(ScaleMax) - q;
    else                      nrm = q;
    wprod = WsumW'($signed({1'b0, nrm}) * pos_weight(cmd.idx));
    qsig  = $signed(quot[PosW-1:0]);
  end

  // PWM mix
  logic signed [PosW:0] lsum, rsum;
  logic [PwmW-1:0]      lclamp, rclamp;
  logic                 found;

  always_comb begin
    lsum   = $signed({6'b0, base_r}) + (PosW+1)'(corr_r);
    rsum   = $signed({6'b0, base_r}) - (PosW+1)'(corr_r);
    lclamp = lsum < 0 ? '0 : (lsum > PwmTop ? PwmW'(PwmTop) : lsum[PwmW-1:0]);
    rclamp = rsum < 0 ? '0 : (rsum > PwmTop ? PwmW'(PwmTop) : rsum[PwmW-1:0]);
    found  = total_r >= thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BaseReset;
      gain_r  <= GainReset;
      thr_r   <= ThrReset;
      minr_r  <= MinrReset;
      black_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:  base_r  <= cfg_data[PwmW-1:0];
        REG_GAIN:  gain_r  <= cfg_data[PwmW-1:0];
        REG_THR:   thr_r   <= cfg_data[ThrW-1:0];
        REG_MINR:  minr_r  <= cfg_data[AdcW-1:0];
        REG_BLACK: black_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumSens; i++) begin
        lo_r[i] <= AdcW'(AdcTop);
        hi_r[i] <= '0;
      end
    end else if (cmd.cal_clr) begin
      for (int i = 0; i < NumSens; i++) begin
        lo_r[i] <= AdcW'(AdcTop);
        hi_r[i] <= '0;
      end
    end else if (cmd.cal_fold) begin
      for (int i = 0; i < NumSens; i++) begin
        if (smp_r[i] < lo_r[i]) lo_r[i] <= smp_r[i];
        if (smp_r[i] > hi_r[i]) hi_r[i] <= smp_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      smp_r   <= in_adc;
      wsum_r  <= '0;
      total_r <= '0;
      pos_r   <= '0;
      corr_r  <= '0;
    end
    if (cmd.div_start && cmd.div_sel == DIV_SCALE) begin
      uncal_r  <= uncal;
      narrow_r <= narrow;
    end
    if (cmd.acc) begin
      case (cmd.div_sel)
        DIV_SCALE: begin
          wsum_r  <= wsum_r + wprod;
          total_r <= total_r + StrW'(nrm);
        end
        DIV_CENT: begin
          if (total_r != '0) pos_r <= wsum_r[WsumW-1] ? -qsig : qsig;
        end
        default: corr_r <= pos_r[PosW-1] ? -qsig : qsig;
      endcase
    end
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        left_r  <= '0;
        right_r <= '0;
        opos_r  <= '0;
        ostr_r  <= '0;
        found_r <= 1'b0;
      end else begin
        left_r  <= found ? lclamp : '0;
        right_r <= found ? rclamp : '0;
        opos_r  <= pos_r;
        ostr_r  <= total_r;
        found_r <= found;
      end
    end
  end

  assign stat.func     = func_r;
  assign stat.div_done = div_done;
  assign left_pwm      = left_r;
  assign right_pwm     = right_r;
  assign centroid      = opos_r;
  assign strength_sum  = ostr_r;
  assign line_found    = found_r;

endmodule

### rtl/line_sensor_position_steering_top.sv
// One item at a time: the next transaction is taken the cycle after the result loads,
// and the result of an item waits while out_stall holds the previous one pending.
// A run item (func 2) uses the single shared 23-step restoring divider: the 6 range
// scales, the centroid divide and the gain divide run on it in turn.
// Reset (rst_n low, synchronous): calibration min/max go to 1023/0, registers
// take their defaults, the controller returns to idle and no result is pending.
module line_sensor_position_steering_top import lsps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FuncW-1:0]       in_func,
  input  logic [AdcW-1:0]        in_adc_ch1,
  input  logic [AdcW-1:0]        in_adc_ch2,
  input  logic [AdcW-1:0]        in_adc_ch3,
  input  logic [AdcW-1:0]        in_adc_ch4,
  input  logic [AdcW-1:0]        in_adc_ch5,
  input  logic [AdcW-1:0]        in_adc_ch6,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PwmW-1:0]        out_left_pwm,
  output logic [PwmW-1:0]        out_right_pwm,
  output logic signed [PosW-1:0] out_centroid,
  output logic [StrW-1:0]        out_strength_sum,
  output logic                   out_line_found,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data
);

  lsps_cmd_t  cmd;
  lsps_stat_t stat;
  logic [AdcW-1:0] adc [NumSens];

  assign adc[0]    = in_adc_ch1;
  assign adc[1]    = in_adc_ch2;
  assign adc[2]    = in_adc_ch3;
  assign adc[3]    = in_adc_ch4;
  assign adc[4]    = in_adc_ch5;
  assign adc[5]    = in_adc_ch6;
  assign cfg_ready = 1'b1;

  lsps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_func),
    .in_adc       (adc),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_pwm     (out_left_pwm),
    .right_pwm    (out_right_pwm),
    .centroid     (out_centroid),
    .strength_sum (out_strength_sum),
    .line_found   (out_line_found)
  );

endmodule

### rtl/lsps_checker.sv
module lsps_checker import lsps_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [PwmW-1:0]        out_left_pwm,
  input logic [PwmW-1:0]        out_right_pwm,
  input logic signed [PosW-1:0] out_centroid,
  input logic [StrW-1:0]        out_strength_sum,
  input logic                   out_line_found
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_found |-> out_left_pwm == '0 && out_right_pwm == '0)
    else $error("motors driven with no line");

  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strength_sum == '0 |-> out_centroid == '0)
    else $error("position nonzero with zero strength");

endmodule

bind line_sensor_position_steering_top lsps_checker u_lsps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_left_pwm     (out_left_pwm),
  .out_right_pwm    (out_right_pwm),
  .out_centroid     (out_centroid),
  .out_strength_sum (out_strength_sum),
  .out_line_found   (out_line_found)
);

### tb/sv/testbench.sv
module testbench;
  import lsps_pkg::*;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [5:0][AdcW-1:0] adc;
  } sample_set_t;

  typedef struct packed {
    logic [PwmW-1:0] left_pwm;
    logic [PwmW-1:0] right_pwm;
    logic [PosW-1:0] position;
    logic [StrW-1:0] strength;
    logic            found;
  } steer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FuncW-1:0] in_func = '0;
  logic [AdcW-1:0] in_adc_ch1 = '0, in_adc_ch2 = '0, in_adc_ch3 = '0;
  logic [AdcW-1:0] in_adc_ch4 = '0, in_adc_ch5 = '0, in_adc_ch6 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PwmW-1:0] out_left_pwm, out_right_pwm;
  logic signed [PosW-1:0] out_centroid;
  logic [StrW-1:0] out_strength_sum;
  logic out_line_found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  line_sensor_position_steering_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [AdcW-1:0] cal_min[6], cal_max[6];
  int unsigned base_spd, gain_div, det_thr, min_range, black_low;

  sample_set_t pending_sets[$];
  steer_t expected_steer[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  bit long_hold = 1'b0;
  int sent_cnt = 0, taken_cnt = 0;
  int gap = 0, burst = 0;
  bit driver_en = 1'b0;

  function automatic int unsigned scale_sensor(int k, logic [AdcW-1:0] s);
    logic [15:0] lo, hi, v, span, off;
    int unsigned q;
    lo = 16'(cal_min[k]);
    hi = 16'(cal_max[k]);
    v = 16'(s);
    span = hi - lo;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    off = v - lo;
    if (span < min_range || span == 0) return 0;
    q = (off * 1000) / span;
    if (q > 1000) q = 1000;
    if (black_low != 0) q = 1000 - q;
    return q;
  endfunction

  function automatic int clamp_duty(int x);
    if (x < 0) return 0;
    if (x > 255) return 255;
    return x;
  endfunction

  function automatic steer_t predict_steer(sample_set_t t);
    steer_t r;
    int wsum, pos, dv, corr;
    int unsigned total, n;
    int wt[6];
    wt = '{-2500, -1500, -500, 500, 1500, 2500};
    r = '0;
    if (t.func == FUNC_CLEAR) begin
      for (int k = 0; k < 6; k++) begin
        cal_min[k] = AdcW'(AdcTop);
        cal_max[k] = '0;
      end
    end else if (t.func == FUNC_CAL) begin
      for (int k = 0; k < 6; k++) begin
        if (t.adc[k] < cal_min[k]) cal_min[k] = t.adc[k];
        if (t.adc[k] > cal_max[k]) cal_max[k] = t.adc[k];
      end
    end else if (t.func == FUNC_RUN) begin
      wsum = 0;
      total = 0;
      pos = 0;
      for (int k = 0; k < 6; k++) begin
        n = scale_sensor(k, t.adc[k]);
        wsum += int'(n) * wt[k];
        total += n;
      end
      if (total != 0) pos = wsum / int'(total);
      r.found = total >= det_thr;
      if (r.found) begin
        dv = (gain_div == 0) ? 1 : gain_div;
        corr = pos / dv;
        r.left_pwm = PwmW'(clamp_duty(int'(base_spd) + corr));
        r.right_pwm = PwmW'(clamp_duty(int'(base_spd) - corr));
      end
      r.position = pos[PosW-1:0];
      r.strength = total[StrW-1:0];
    end
    return r;
  endfunction

  // driver: an offered transaction stays put until the monitor has seen it taken
  always @(negedge clk) begin
    if (!in_valid || sent_cnt == taken_cnt) begin
      if (driver_en && pending_sets.size() > 0 && gap == 0) begin
        sample_set_t t;
        t = pending_sets[0];
        in_valid <= 1'b1;
        in_func <= t.func;
        {in_adc_ch6, in_adc_ch5, in_adc_ch4, in_adc_ch3, in_adc_ch2, in_adc_ch1} <= t.adc;
        sent_cnt++;
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end else burst--;
      end else begin
        in_valid <= 1'b0;
        if (gap > 0) gap--;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (long_hold && hold_cnt < 1500) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else out_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 9) != 0);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken_cnt++;
        expected_steer.push_back(predict_steer(pending_sets.pop_front()));
      end
      if (out_valid && !out_stall) begin
        steer_t got, want;
        got = {out_left_pwm, out_right_pwm, out_centroid, out_strength_sum,
               out_line_found};
        if (expected_steer.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_steer.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp l%0d r%0d p%0d s%0d f%0d got l%0d r%0d p%0d s%0d f%0d",
                       want.left_pwm, want.right_pwm, $signed(want.position),
                       want.strength, want.found, got.left_pwm, got.right_pwm,
                       $signed(got.position), got.strength, got.found);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CfgDataW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE: base_spd = val & 8'hff;
      REG_GAIN: gain_div = val & 8'hff;
      REG_THR: det_thr = val & 13'h1fff;
      REG_MINR: min_range = val & 10'h3ff;
      default: black_low = val & 1;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_sets.size() > 0 || expected_steer.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic sample_set_t mk(logic [FuncW-1:0] f, logic [AdcW-1:0] a);
    sample_set_t t;
    t.func = f;
    for (int k = 0; k < 6; k++) t.adc[k] = a;
    return t;
  endfunction

  function automatic sample_set_t rnd_set(logic [FuncW-1:0] f);
    sample_set_t t;
    t.func = f;
    for (int k = 0; k < 6; k++) t.adc[k] = AdcW'($urandom_range(0, 1023));
    return t;
  endfunction

  task automatic random_phase(int count);
    sample_set_t t;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: t = mk(FUNC_CLEAR, AdcW'($urandom_range(0, 1023)));
        1: t = rnd_set(FUNC_RSVD);
        2, 3, 4: t = rnd_set(FUNC_CAL);
        default: t = rnd_set(FUNC_RUN);
      endcase
      pending_sets.push_back(t);
    end
  endtask

  initial begin
    sample_set_t t;
    for (int k = 0; k < 6; k++) begin
      cal_min[k] = AdcW'(AdcTop);
      cal_max[k] = '0;
    end
    base_spd = 100; gain_div = 20; det_thr = 300; min_range = 30; black_low = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    driver_en = 1'b1;

    // directed: uncalibrated run, unused code, calibration extremes, narrow range
    pending_sets.push_back(mk(FUNC_RUN, 10'd0));
    pending_sets.push_back(mk(FUNC_RSVD, 10'h3ff));
    pending_sets.push_back(mk(FUNC_CAL, 10'd0));
    pending_sets.push_back(mk(FUNC_RUN, 10'd0));
    pending_sets.push_back(mk(FUNC_CAL, 10'h3ff));
    pending_sets.push_back(mk(FUNC_RUN, 10'h3ff));
    pending_sets.push_back(mk(FUNC_RUN, 10'd0));
    pending_sets.push_back(mk(FUNC_RUN, 10'd512));
    t = mk(FUNC_RUN, 10'h3ff); t.adc[0] = 0;
    pending_sets.push_back(t);
    t = mk(FUNC_RUN, 10'h3ff); t.adc[5] = 0;
    pending_sets.push_back(t);
    pending_sets.push_back(mk(FUNC_CLEAR, 10'd0));
    pending_sets.push_back(mk(FUNC_CAL, 10'd500));
    pending_sets.push_back(mk(FUNC_CAL, 10'd510));
    pending_sets.push_back(mk(FUNC_RUN, 10'd505));
    pending_sets.push_back(mk(FUNC_CAL, 10'd100));
    // long receiver hold-off while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) pending_sets.push_back(rnd_set(FUNC_RUN));
    drain();

    write_reg(REG_BLACK, 0);
    write_reg(REG_GAIN, 1);
    write_reg(REG_BASE, 255);
    write_reg(REG_THR, 0);
    write_reg(REG_MINR, 0);
    random_phase(450);
    drain();

    write_reg(REG_GAIN, 0);
    write_reg(REG_BASE, 0);
    write_reg(REG_THR, 6000);
    write_reg(REG_MINR, 1023);
    write_reg(REG_BLACK, 1);
    random_phase(300);
    drain();

    write_reg(REG_GAIN, 255);
    write_reg(REG_BASE, 128);
    write_reg(REG_THR, 8191);
    write_reg(REG_MINR, 600);
    random_phase(200);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_BASE, $urandom_range(0, 255));
      write_reg(REG_GAIN, $urandom_range(1, 40));
      write_reg(REG_THR, $urandom_range(0, 3000));
      write_reg(REG_MINR, $urandom_range(0, 200));
      write_reg(REG_BLACK, $urandom_range(0, 1));
      random_phase(210);
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
